/* hw/rtl/duplicate_event_suppress_cache_macros.svh */
// ----------------------------------------------------------------------------
// duplicate_event_suppress_cache_macros
// assertion helpers for the checker of the event cache
// ----------------------------------------------------------------------------
`ifndef DUPLICATE_EVENT_SUPPRESS_CACHE_MACROS_SVH
`define DUPLICATE_EVENT_SUPPRESS_CACHE_MACROS_SVH

// same-cycle implication, reset masks the check
`define DSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, reset masks the check
`define DSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/dsc_pkg.sv */
// ----------------------------------------------------------------------------
// dsc_pkg
// widths, outcome codes and result type of the duplicate event cache
// ----------------------------------------------------------------------------
package dsc_pkg;

	localparam int SIG_W     = 32;
	localparam int TS_W      = 64;
	localparam int OUTCOME_W = 2;
	localparam int SLOT_W    = 6;

	localparam logic [TS_W-1:0] WINDOW_RST = 64'd10000000;

	// outcome codes
	localparam logic [OUTCOME_W-1:0] OUT_SUPPRESS = 2'd0;
	localparam logic [OUTCOME_W-1:0] OUT_REFRESH  = 2'd1;
	localparam logic [OUTCOME_W-1:0] OUT_INSERT   = 2'd2;
	localparam logic [OUTCOME_W-1:0] OUT_EVICT    = 2'd3;

	typedef struct packed {
		logic                 report;
		logic [OUTCOME_W-1:0] outcome;
		logic [SLOT_W-1:0]    slot_used;
	} res_t;

endpackage

/* hw/rtl/dsc_front.sv */
// ----------------------------------------------------------------------------
// dsc_front
// takes an event, fixes a zero signature and reduces it to its home slot
// ----------------------------------------------------------------------------
module dsc_front import dsc_pkg::*; #(
	parameter int SLOT_COUNT = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [SIG_W-1:0]     signature,
	input  logic [TS_W-1:0]      timestamp,
	output logic                 busy,
	output logic                 push_valid,
	input  logic                 push_ready,
	output logic [SIG_W-1:0]     push_sig,
	output logic [TS_W-1:0]      push_ts,
	output logic [(SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1)-1:0] push_home
);

	localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	// quotient by reciprocal multiplication, exact for every 32-bit signature:
	// q = (n * ceil(2^(SIG_W+LOG_M) / SLOT_COUNT)) >> (SIG_W+LOG_M)
	localparam int LOG_M  = $clog2(SLOT_COUNT);
	localparam int SHIFT  = SIG_W + LOG_M;
	localparam int MAG_W  = SIG_W + 1;
	localparam int PROD_W = SIG_W + MAG_W;

	localparam logic [63:0]      POW2    = 64'd1 << SHIFT;
	localparam logic [MAG_W-1:0] MAGIC   =
		MAG_W'((POW2 + 64'(SLOT_COUNT) - 64'd1) / 64'(SLOT_COUNT));
	localparam logic [SIG_W-1:0] DIVISOR = SIG_W'(SLOT_COUNT);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_MUL  = 2'd1;
	localparam logic [1:0] F_REM  = 2'd2;
	localparam logic [1:0] F_PUSH = 2'd3;

	logic [1:0]        state_q;
	logic [SIG_W-1:0]  sig_q;
	logic [TS_W-1:0]   ts_q;
	logic [PROD_W-1:0] prod_q;
	logic [IDX_W-1:0]  rem_q;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] prod_shr;
	logic [SIG_W-1:0]  quot;
	logic [SIG_W-1:0]  back_prod;
	logic [SIG_W-1:0]  rem_full;
	logic [IDX_W-1:0]  rem_nxt;

	// F_MUL step: signature times the reciprocal
	assign prod      = {{MAG_W{1'b0}}, sig_q} * {{SIG_W{1'b0}}, MAGIC};
	// F_REM step: remainder from the quotient
	assign prod_shr  = prod_q >> SHIFT;
	assign quot      = prod_shr[SIG_W-1:0];
	assign back_prod = quot * DIVISOR;
	assign rem_full  = sig_q - back_prod;
	assign rem_nxt   = rem_full[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (start) begin
						state_q <= F_MUL;
					end
				end
				F_MUL: state_q <= F_REM;
				F_REM: state_q <= F_PUSH;
				F_PUSH: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && start) begin
			// zero is the empty mark, so it is folded onto one
			sig_q <= (signature == '0) ? SIG_W'(1) : signature;
			ts_q  <= timestamp;
		end
		if (state_q == F_MUL) begin
			prod_q <= prod;
		end
		if (state_q == F_REM) begin
			rem_q <= rem_nxt;
		end
	end

	assign busy       = (state_q != F_IDLE);
	assign push_valid = (state_q == F_PUSH);
	assign push_sig   = sig_q;
	assign push_ts    = ts_q;
	assign push_home  = rem_q;

endmodule

/* hw/rtl/dsc_fifo.sv */
// ----------------------------------------------------------------------------
// dsc_fifo
// small first-in first-out queue between the front and the back
// ----------------------------------------------------------------------------
module dsc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign wr_ready = (count_q != CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = entry_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

/* hw/rtl/dsc_back.sv */
// ----------------------------------------------------------------------------
// dsc_back
// probe engine: walks the slot table from the home slot and updates it
// ----------------------------------------------------------------------------
module dsc_back import dsc_pkg::*; #(
	parameter int SLOT_COUNT = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [TS_W-1:0]      window,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  logic [SIG_W-1:0]     pop_sig,
	input  logic [TS_W-1:0]      pop_ts,
	input  logic [(SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1)-1:0] pop_home,
	output logic                 clearing,
	output logic                 res_valid,
	output res_t                 res
);

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int ENT_W = SIG_W + TS_W;

	localparam logic [1:0] B_CLR  = 2'd0;
	localparam logic [1:0] B_IDLE = 2'd1;
	localparam logic [1:0] B_RD   = 2'd2;
	localparam logic [1:0] B_CMP  = 2'd3;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

	// slot table: signature in the upper bits, last-seen time below
	logic [ENT_W-1:0] table_mem [SLOT_COUNT];
	logic [ENT_W-1:0] rd_q;

	logic [1:0]       state_q;
	logic [IDX_W-1:0] clr_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] home_q;
	logic [SIG_W-1:0] sig_q;
	logic [TS_W-1:0]  ts_q;
	logic             done_q;
	res_t             res_q;

	logic [SIG_W-1:0] rd_sig;
	logic [TS_W-1:0]  rd_last;
	logic [TS_W-1:0]  elapsed;
	logic             hit;
	logic             empty;
	logic             last_probe;
	logic             recent;
	logic             mem_we;
	logic [IDX_W-1:0] mem_addr;
	logic [ENT_W-1:0] mem_wdata;
	logic [IDX_W-1:0] idx_nxt;

	assign rd_sig     = rd_q[ENT_W-1:TS_W];
	assign rd_last    = rd_q[TS_W-1:0];
	assign elapsed    = ts_q - rd_last;
	assign hit        = (rd_sig == sig_q);
	assign empty      = (rd_sig == '0);
	assign last_probe = (cnt_q == LAST_IDX);
	assign recent     = (elapsed < window);
	assign idx_nxt    = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;

	// table write port
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = idx_q;
		mem_wdata = {sig_q, ts_q};
		if (state_q == B_CLR) begin
			mem_we    = 1'b1;
			mem_addr  = clr_q;
			mem_wdata = '0;
		end else if (state_q == B_CMP) begin
			priority if (hit) begin
				mem_we = !recent;
			end else if (empty) begin
				mem_we = 1'b1;
			end else if (last_probe) begin
				mem_we   = 1'b1;
				mem_addr = home_q;
			end else begin
				mem_we = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[mem_addr] <= mem_wdata;
		end
		if (state_q == B_RD) begin
			rd_q <= table_mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				B_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_IDX) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (pop_valid) begin
						state_q <= B_RD;
					end
				end
				B_RD: state_q <= B_CMP;
				B_CMP: begin
					if (hit || empty || last_probe) begin
						done_q  <= 1'b1;
						state_q <= B_IDLE;
					end else begin
						state_q <= B_RD;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && pop_valid) begin
			sig_q  <= pop_sig;
			ts_q   <= pop_ts;
			home_q <= pop_home;
			idx_q  <= pop_home;
			cnt_q  <= '0;
		end else if (state_q == B_CMP) begin
			idx_q <= idx_nxt;
			cnt_q <= cnt_q + 1'b1;
			priority if (hit) begin
				res_q.report    <= !recent;
				res_q.outcome   <= recent ? OUT_SUPPRESS : OUT_REFRESH;
				res_q.slot_used <= SLOT_W'(idx_q);
			end else if (empty) begin
				res_q.report    <= 1'b1;
				res_q.outcome   <= OUT_INSERT;
				res_q.slot_used <= SLOT_W'(idx_q);
			end else begin
				res_q.report    <= 1'b1;
				res_q.outcome   <= OUT_EVICT;
				res_q.slot_used <= SLOT_W'(home_q);
			end
		end
	end

	assign pop_ready = (state_q == B_IDLE);
	assign clearing  = (state_q == B_CLR);
	assign res_valid = done_q;
	assign res       = res_q;

endmodule

/* hw/rtl/duplicate_event_suppress_cache.sv */
// ----------------------------------------------------------------------------
// duplicate_event_suppress_cache
// reports an event or suppresses it as a recent duplicate, using a linearly
// probed table of signature and last-seen time
// ----------------------------------------------------------------------------
//
//   channel   handshake           payload
//   -------   -----------------   -----------------------------------
//   event     start / busy        signature, timestamp
//   result    done (one cycle)    report, outcome, slot_used
//   config    cfg_we              cfg_wdata (dup_window)
//
// an event transfer takes the front through accept, a reciprocal multiply
// for the home-slot quotient, the remainder and the hand-off to the queue
// the back probes p slots for an event, one table read and one compare per
// slot, p from 1 up to SLOT_COUNT
// a two-entry queue lets the front take the next event while the back probes
// after reset the table is swept empty one slot a cycle, with busy held
// high until the sweep ends
// results are driven for exactly one cycle with done; there is no stall
//
module duplicate_event_suppress_cache import dsc_pkg::*; #(
	parameter int SLOT_COUNT = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [SIG_W-1:0]        signature,
	input  logic [TS_W-1:0]         timestamp,
	output logic                    done,
	output logic                    report,
	output logic [OUTCOME_W-1:0]    outcome,
	output logic [SLOT_W-1:0]       slot_used,
	input  logic                    cfg_we,
	input  logic [TS_W-1:0]         cfg_wdata
);

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int Q_W   = SIG_W + TS_W + IDX_W;

	// suppression window register
	logic [TS_W-1:0] window_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RST;
		end else if (cfg_we) begin
			window_q <= cfg_wdata;
		end
	end

	// front to queue
	logic             front_busy;
	logic             push_valid;
	logic             push_ready;
	logic [SIG_W-1:0] push_sig;
	logic [TS_W-1:0]  push_ts;
	logic [IDX_W-1:0] push_home;

	// queue to back
	logic             pop_valid;
	logic             pop_ready;
	logic [Q_W-1:0]   pop_data;

	logic             clearing;
	logic             res_valid;
	res_t             res;

	// no event transfer while the table sweep runs
	assign busy = front_busy || clearing;

	dsc_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start && !clearing),
		.signature  (signature),
		.timestamp  (timestamp),
		.busy       (front_busy),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_sig   (push_sig),
		.push_ts    (push_ts),
		.push_home  (push_home)
	);

	dsc_fifo #(.WIDTH(Q_W), .DEPTH(2)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_data  ({push_sig, push_ts, push_home}),
		.rd_valid (pop_valid),
		.rd_ready (pop_ready),
		.rd_data  (pop_data)
	);

	dsc_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.window    (window_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_sig   (pop_data[Q_W-1 -: SIG_W]),
		.pop_ts    (pop_data[IDX_W +: TS_W]),
		.pop_home  (pop_data[IDX_W-1:0]),
		.clearing  (clearing),
		.res_valid (res_valid),
		.res       (res)
	);

	// results come straight from the back's output registers
	assign done      = res_valid;
	assign report    = res.report;
	assign outcome   = res.outcome;
	assign slot_used = res.slot_used;

endmodule

/* hw/rtl/dsc_checker.sv */
// ----------------------------------------------------------------------------
// dsc_checker
// port-level checks of the duplicate event cache, bound to the top level
// ----------------------------------------------------------------------------
`include "duplicate_event_suppress_cache_macros.svh"

module dsc_checker import dsc_pkg::*; #(
	parameter int SLOT_COUNT = 64
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 done,
	input logic                 report,
	input logic [OUTCOME_W-1:0] outcome,
	input logic [SLOT_W-1:0]    slot_used
);

	// only a suppressed event goes unreported
	`DSC_ASSERT_NOW(a_report_outcome, clk, arst_n, done, report == (outcome != OUT_SUPPRESS), "report disagrees with outcome")

	// an accepted event keeps the block busy in the next cycle
	`DSC_ASSERT_NEXT(a_busy_after_start, clk, arst_n, start && !busy, busy, "busy not raised after event transfer")

	// each probe takes a read and a compare, so results never come back to back
	`DSC_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done, "done held for more than one cycle")

	// a reported slot lies inside the table
	`DSC_ASSERT_NOW(a_slot_range, clk, arst_n, done, SLOT_COUNT > 63 || 32'(slot_used) < SLOT_COUNT, "slot outside the table")

endmodule

bind duplicate_event_suppress_cache dsc_checker #(.SLOT_COUNT(SLOT_COUNT)) u_dsc_checker (.*);

/* tb/tb_duplicate_event_suppress_cache.sv */
// ----------------------------------------------------------------------------
// tb_duplicate_event_suppress_cache
// self-checking bench for the duplicate event cache: a software copy of the
// probed signature table predicts report, outcome and slot for every event
// transfer and the results are compared in order as they come out
// ----------------------------------------------------------------------------
module tb_duplicate_event_suppress_cache;
	timeunit 1ns;
	timeprecision 1ps;

	import dsc_pkg::*;

	localparam int SLOTS = 64;
	// slowest event: the front steps plus a full-table probe
	localparam int TAIL_CYCLES = 2 * SLOTS + 16;
	// timeout in ns, several times the slowest legal run
	localparam int TIMEOUT_NS = 10_000_000;
	localparam int REPORT_LIMIT = 10;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [SIG_W-1:0]     signature;
	logic [TS_W-1:0]      timestamp;
	logic                 done;
	logic                 report;
	logic [OUTCOME_W-1:0] outcome;
	logic [SLOT_W-1:0]    slot_used;
	logic                 cfg_we;
	logic [TS_W-1:0]      cfg_wdata;

	// ------------------------------------------------------------------------
	// table mirror and in-order verdict checker
	// ------------------------------------------------------------------------
	class verdict_checker;
		logic [SIG_W-1:0] slot_sig[SLOTS];
		logic [TS_W-1:0]  slot_seen[SLOTS];
		logic [TS_W-1:0]  window;
		res_t             verdicts_due[$];
		int               failures;

		function new();
			foreach (slot_sig[i]) begin
				slot_sig[i]  = '0;
				slot_seen[i] = '0;
			end
			window   = WINDOW_RST;
			failures = 0;
		endfunction

		// walk the table the way the block does and queue the verdict
		function void note_event(input logic [SIG_W-1:0] sig, input logic [TS_W-1:0] ts);
			logic [SIG_W-1:0] key;
			logic [TS_W-1:0]  elapsed;
			int               home;
			int               idx;
			res_t             verdict;
			// zero is reserved for an empty slot, so it folds onto one
			key  = (sig == '0) ? 1 : sig;
			home = key % SLOTS;
			for (int i = 0; i < SLOTS; i++) begin
				idx = (home + i) % SLOTS;
				if (slot_sig[idx] == key) begin
					// elapsed time wraps modulo 2^64
					elapsed = ts - slot_seen[idx];
					verdict.slot_used = idx[SLOT_W-1:0];
					if (elapsed < window) begin
						verdict.report  = 1'b0;
						verdict.outcome = OUT_SUPPRESS;
					end else begin
						slot_seen[idx]  = ts;
						verdict.report  = 1'b1;
						verdict.outcome = OUT_REFRESH;
					end
					verdicts_due.push_back(verdict);
					return;
				end
				if (slot_sig[idx] == '0) begin
					slot_sig[idx]     = key;
					slot_seen[idx]    = ts;
					verdict.report    = 1'b1;
					verdict.outcome   = OUT_INSERT;
					verdict.slot_used = idx[SLOT_W-1:0];
					verdicts_due.push_back(verdict);
					return;
				end
			end
			// table full and no match: the home slot gets overwritten
			slot_sig[home]    = key;
			slot_seen[home]   = ts;
			verdict.report    = 1'b1;
			verdict.outcome   = OUT_EVICT;
			verdict.slot_used = home[SLOT_W-1:0];
			verdicts_due.push_back(verdict);
		endfunction

		function void check_verdict(input logic rep, input logic [OUTCOME_W-1:0] oc,
				input logic [SLOT_W-1:0] slot);
			res_t want;
			if (verdicts_due.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("%0t: result with no event outstanding: report=%0d outcome=%0d slot=%0d",
						$realtime, rep, oc, slot);
				return;
			end
			want = verdicts_due.pop_front();
			if (rep !== want.report || oc !== want.outcome || slot !== want.slot_used) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("%0t: mismatch expected report=%0d outcome=%0d slot=%0d, got report=%0d outcome=%0d slot=%0d",
						$realtime, want.report, want.outcome, want.slot_used, rep, oc, slot);
			end
		endfunction
	endclass

	verdict_checker verdicts = new();

	duplicate_event_suppress_cache #(
		.SLOT_COUNT (SLOTS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.signature  (signature),
		.timestamp  (timestamp),
		.done       (done),
		.report     (report),
		.outcome    (outcome),
		.slot_used  (slot_used),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs or drops a result
	initial begin
		#(TIMEOUT_NS);
		$display("Simulation FAILED");
		$finish;
	end

	// results live for one cycle only; sampled at the edge that ends it
	always @(posedge clk) begin
		if (arst_n && done)
			verdicts.check_verdict(report, outcome, slot_used);
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [63:0] rand_below(input logic [63:0] bound);
		if (bound == '0)
			return '0;
		return rand64() % bound;
	endfunction

	// clock advance between events, scaled to the window so repeats of a
	// signature land on both sides of it; a few jumps go anywhere, backwards too
	function automatic logic [63:0] clock_step(input logic [63:0] w);
		int r;
		r = $urandom_range(99);
		if (w == '0)
			return $urandom_range(0, 50);
		if (r < 80)
			return rand_below((w >> 3) + 2);
		if (r < 95)
			return w + rand_below(w);
		return rand64();
	endfunction

	// one event transfer: held until a rising edge finds busy low
	task automatic send_event(input logic [SIG_W-1:0] sig, input logic [TS_W-1:0] ts);
		@(negedge clk);
		start     <= 1'b1;
		signature <= sig;
		timestamp <= ts;
		do
			@(posedge clk);
		while (busy);
		verdicts.note_event(sig, ts);
	endtask

	// sender goes quiet for a random number of cycles
	task automatic idle_gap();
		@(negedge clk);
		start <= 1'b0;
		repeat ($urandom_range(0, 14)) @(negedge clk);
	endtask

	// hold off the sender until every queued verdict is back and the block
	// has gone idle (also covers the table sweep after reset)
	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (verdicts.verdicts_due.size() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic set_window(input logic [TS_W-1:0] w);
		drain_results();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= w;
		verdicts.window = w;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// hand-picked events: zero signature, home collisions, probing across the
	// last slot, timestamp wrap, elapsed equal to the window, window extremes
	task automatic directed_events();
		send_event(32'd0, 64'd0);
		send_event(32'd1, 64'd5);
		send_event(32'd65, 64'd10);
		send_event(32'hFFFF_FFFF, '1);
		send_event(32'hFFFF_FFBF, 64'd0);
		send_event(32'hFFFF_FFFF, 64'd3);
		send_event(32'd1, 64'd10_000_005);
		send_event(32'd1, 64'd20_000_004);
		send_event(32'd65, 64'h8000_0000_0000_0000);
		// zero window never suppresses, not even an identical stamp
		set_window('0);
		send_event(32'd1, 64'd20_000_004);
		send_event(32'h8000_0000, 64'h5555_5555_5555_5555);
		// widest window: only an elapsed time of all ones gets through
		set_window('1);
		send_event(32'd1, 64'd20_000_003);
		send_event(32'd1, 64'hAAAA_AAAA_AAAA_AAAA);
		send_event(32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		send_event(32'hAAAA_AAAA, 64'h5555_5555_5555_5555);
		set_window(64'd1);
		send_event(32'hAAAA_AAAA, 64'h5555_5555_5555_5555);
		send_event(32'hAAAA_AAAA, 64'h5555_5555_5555_5556);
	endtask

	// mostly repeats from a small pool of signatures, many sharing home slots
	// near the wrap point, plus fresh signatures that fill and then evict
	task automatic random_phase(input int count, input logic [TS_W-1:0] w, input bit gaps);
		logic [SIG_W-1:0] pool[20];
		logic [SIG_W-1:0] sig;
		logic [SIG_W-1:0] tmp;
		logic [TS_W-1:0]  clock_now;
		int               hot;
		int               r;
		set_window(w);
		foreach (pool[k]) begin
			tmp = $urandom();
			hot = (60 + $urandom_range(0, 7)) % SLOTS;
			pool[k] = (k < 10) ? {tmp[SIG_W-1:6], hot[5:0]} : tmp;
		end
		clock_now = rand64();
		for (int n = 0; n < count; n++) begin
			if (gaps && $urandom_range(99) < 11)
				idle_gap();
			r = $urandom_range(99);
			if (r < 80)
				sig = pool[$urandom_range(19)];
			else if (r < 98)
				sig = $urandom();
			else
				sig = '0;
			clock_now += clock_step(w);
			send_event(sig, clock_now);
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		signature = '0;
		timestamp = '0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// first events run on the reset window
		directed_events();

		random_phase(150, 64'd5000, 1'b1);
		random_phase(150, 64'd1, 1'b1);
		random_phase(150, 64'd0, 1'b1);
		// back-to-back stretch with no sender gaps
		random_phase(150, '1, 1'b0);
		random_phase(150, rand64() >> $urandom_range(0, 63), 1'b1);
		random_phase(150, WINDOW_RST, 1'b1);

		drain_results();
		// stray results would show up within one full-table probe
		repeat (TAIL_CYCLES) @(posedge clk);

		if (verdicts.failures == 0 && verdicts.verdicts_due.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
